FILE: rtl/shs_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package shs_pkg;

  // Padding marker byte and the byte position where the bit length starts
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  // Initial hash value, word 0 first
  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Controls from the sequencer to the message schedule
  typedef struct packed {
    logic load;    // shift one message byte in
    logic expand;  // advance the schedule by one round
  } sched_ctl_t;

  // Controls from the sequencer to the round unit
  typedef struct packed {
    logic init;     // copy chaining words into the working variables
    logic step;     // run one compression round
    logic fold;     // add working variables into the chaining words
    logic restore;  // return chaining words to the initial hash value
  } round_ctl_t;

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: handshakes, padding sequencer, length counter.
// Depends on shs_pkg, shs_sched and shs_round.
//
// Usage: the slave channel takes one transaction per message byte; s_tuser
// marks that s_tdata holds a byte and s_tlast ends the message (that
// transaction may carry no byte). The master channel returns the digest as
// eight transactions of one 32-bit word each, word 0 first, with m_tlast on
// the eighth. Then the hasher starts over with the initial hash value.
// The 64th byte of a block starts the rounds and then the fold in the single
// round unit, during which s_tready is low. An end transaction feeds padding
// bytes one per cycle through the same byte path until the final block is
// full (fill = bytes held), plus one more pad block when fill is 56 or more,
// each block followed by its compression, then the eight digest words.
// s_tready is low from an end transaction until the last word is taken; a
// stall on m_tready simply holds the current word. Reset is synchronous and
// returns the initial hash value, an empty buffer and a zero length.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] byte_valid
  input  wire logic        s_tlast,   // end_of_message
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic             m_tlast    // last_word
);

  typedef enum logic [2:0] {IDLE, PAD, COMPRESS, FOLD, OUT} state_t;

  state_t              state;
  logic [5:0]          fill;
  logic [5:0]          round_cnt;
  logic [2:0]          out_idx;
  logic [63:0]         bit_count;
  logic                pad_active;
  logic                mark_sent;
  logic                spill;
  logic                len_done;

  logic                s_fire;
  logic                m_fire;
  logic                push;
  logic                len_byte;
  logic [7:0]          push_byte;
  logic [31:0]         wt;
  logic [31:0]         chain_word;
  shs_pkg::sched_ctl_t sched_ctl;
  shs_pkg::round_ctl_t round_ctl;

  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (state == OUT);
  assign m_fire   = m_tvalid && m_tready;
  assign m_tdata  = {5'b0, out_idx, chain_word};
  assign m_tlast  = (out_idx == shs_pkg::LAST_WORD);

  // Pick the byte to buffer: a message byte or a padding byte
  assign len_byte = mark_sent && !spill && (fill >= shs_pkg::LEN_OFFSET);
  always_comb begin
    if (state == IDLE) begin
      push_byte = s_tdata;
    end else if (!mark_sent) begin
      push_byte = shs_pkg::PAD_MARK;
    end else if (len_byte) begin
      push_byte = bit_count[63:56];
    end else begin
      push_byte = 8'h00;
    end
  end

  assign push = (s_fire && s_tuser) || (state == PAD);

  assign sched_ctl.load   = push;
  assign sched_ctl.expand = (state == COMPRESS);

  assign round_ctl.init    = push && (fill == shs_pkg::LAST_BYTE);
  assign round_ctl.step    = (state == COMPRESS);
  assign round_ctl.fold    = (state == FOLD);
  assign round_ctl.restore = m_fire && m_tlast;

  shs_sched u_sched (
    .clk       (clk),
    .ctl       (sched_ctl),
    .byte_in   (push_byte),
    .byte_lane (fill[1:0]),
    .wt        (wt)
  );

  shs_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctl        (round_ctl),
    .round_idx  (round_cnt),
    .wt         (wt),
    .word_sel   (out_idx),
    .chain_word (chain_word)
  );

  // Sequence bytes, padding, rounds and digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      fill       <= '0;
      round_cnt  <= '0;
      out_idx    <= '0;
      bit_count  <= '0;
      pad_active <= 1'b0;
      mark_sent  <= 1'b0;
      spill      <= 1'b0;
      len_done   <= 1'b0;
    end else begin
      if (push) begin
        fill <= fill + 6'd1;
      end
      case (state)
        IDLE: begin
          if (s_fire) begin
            if (s_tuser) begin
              bit_count <= bit_count + 64'd8;
            end
            pad_active <= s_tlast;
            if (s_tuser && (fill == shs_pkg::LAST_BYTE)) begin
              state     <= COMPRESS;
              round_cnt <= '0;
            end else if (s_tlast) begin
              state <= PAD;
            end
          end
        end
        PAD: begin
          if (!mark_sent) begin
            mark_sent <= 1'b1;
            spill     <= (fill >= shs_pkg::LEN_OFFSET);
          end else if (len_byte) begin
            bit_count <= {bit_count[55:0], 8'h00};
            if (fill == shs_pkg::LAST_BYTE) begin
              len_done <= 1'b1;
            end
          end
          if (fill == shs_pkg::LAST_BYTE) begin
            state     <= COMPRESS;
            round_cnt <= '0;
          end
        end
        COMPRESS: begin
          round_cnt <= round_cnt + 6'd1;
          if (round_cnt == shs_pkg::LAST_ROUND) begin
            state <= FOLD;
          end
        end
        FOLD: begin
          if (len_done) begin
            state   <= OUT;
            out_idx <= '0;
          end else if (pad_active) begin
            state <= PAD;
            spill <= 1'b0;
          end else begin
            state <= IDLE;
          end
        end
        OUT: begin
          if (m_fire) begin
            out_idx <= out_idx + 3'd1;
            if (m_tlast) begin
              state      <= IDLE;
              pad_active <= 1'b0;
              mark_sent  <= 1'b0;
              spill      <= 1'b0;
              len_done   <= 1'b0;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output handshakes open at once");

  // A block is folded only after all 64 bytes were buffered
  a_fold_full: assert property (@(posedge clk) disable iff (rst)
    (state == FOLD) |-> (fill == 6'd0))
    else $error("fold with a partly filled block");

  // The length has been shifted out entirely by the time the digest goes out
  a_len_spent: assert property (@(posedge clk) disable iff (rst)
    (state == OUT) |-> (bit_count == 64'd0))
    else $error("length not fully written into the final block");

  // Length completion implies padding with its marker byte
  a_len_order: assert property (@(posedge clk) disable iff (rst)
    len_done |-> (mark_sent && pad_active))
    else $error("length written without padding marker");

  // The digest always starts at word 0
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (out_idx == 3'd0))
    else $error("digest does not start at word 0");

endmodule

`default_nettype wire

FILE: rtl/shs_sched.sv
// Message schedule: packs bytes into a 16-word window and expands it one word per round.
// Depends on shs_pkg for the control struct.
`default_nettype none

module shs_sched (
  input  wire logic               clk,
  input  wire shs_pkg::sched_ctl_t ctl,
  input  wire logic [7:0]         byte_in,
  input  wire logic [1:0]         byte_lane,  // position of byte_in within its word
  output logic [31:0]             wt          // schedule word for the current round
);

  logic [23:0] acc;
  logic [31:0] win [16];
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;

  // Small sigma functions on fixed taps of the window
  assign s0 = {win[1][6:0], win[1][31:7]} ^ {win[1][17:0], win[1][31:18]} ^
              {3'b000, win[1][31:3]};
  assign s1 = {win[14][16:0], win[14][31:17]} ^ {win[14][18:0], win[14][31:19]} ^
              {10'b0, win[14][31:10]};
  assign w_new = win[0] + s0 + win[9] + s1;
  assign wt = win[0];

  // Collect bytes big-endian, shift full words into the window, or expand
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (byte_lane == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i + 1];
        end
        win[15] <= {acc, byte_in};
      end else begin
        acc <= {acc[15:0], byte_in};
      end
    end else if (ctl.expand) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_new;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/shs_round.sv
// Round unit: eight working variables, one compression round per cycle while step is set, chaining words.
// Depends on shs_pkg for the control struct, round constants and initial hash value.
`default_nettype none

module shs_round (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire shs_pkg::round_ctl_t ctl,
  input  wire logic [5:0]         round_idx,
  input  wire logic [31:0]        wt,
  input  wire logic [2:0]         word_sel,
  output logic [31:0]             chain_word
);

  logic [31:0] chain [8];
  logic [31:0] v [8];   // a..h
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] t1;
  logic [31:0] t2;

  // Round function on a..h
  assign big1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
                {v[4][24:0], v[4][31:25]};
  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1 = v[7] + big1 + choose + shs_pkg::round_k(round_idx) + wt;
  assign big0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
                {v[0][21:0], v[0][31:22]};
  assign major = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2 = big0 + major;

  assign chain_word = chain[word_sel];

  // Hold chaining words; fold after each block, restore after each digest
  always_ff @(posedge clk) begin
    if (rst || ctl.restore) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= shs_pkg::INIT_HASH[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

  // Advance the working variables
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (ctl.step) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

endmodule

`default_nettype wire
